>>> hw/rtl/deq_pkg.sv
// shared types for the double-ended queue: request kinds, result status codes and widths
// no dependencies
package deq_pkg;

   typedef enum logic [1:0] {
      REQ_PUSH_BACK  = 2'd0,
      REQ_PUSH_FRONT = 2'd1,
      REQ_POP_BACK   = 2'd2,
      REQ_POP_FRONT  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam int unsigned OCC_WIDTH = 5;
   localparam int unsigned WORD_WIDTH = 32;

endpackage

>>> hw/rtl/double_ended_queue.sv
// double-ended queue top level: ring of words in a ram with front/back pointers and a count
// depends on deq_pkg and deq_ram
//
// usage:
//   req channel: req_tuser selects push back, push front, pop back or pop front;
//   req_tdata carries the word to push (ignored for pops).
//   rsp channel: one item per request; rsp_tdata holds the popped word (zero for
//   pushes and failed pops) and the occupancy after the request, rsp_tuser the status
//   (ok, pop on empty, push on full). failed requests leave the queue unchanged.
//   timing: a push or a failed pop shows its result in the cycle after acceptance;
//   a successful pop shows it once the registered ram read returns.
//   a push or a failed pop does not hold off the next request; a successful pop
//   holds it off until the registered read of the word ram returns.
//   the result sits in an output register; a new request is taken in the same
//   cycle that the previous result is taken. while rsp_tready is low and a result
//   waits, req_tready stays low.
//   reset clears the pointers, count and output valid; ram contents are not
//   cleared and are only read where a push wrote them.
module double_ended_queue #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] pop_value, [36:32] occupancy, [39:37] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned OCC_W = deq_pkg::OCC_WIDTH;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      pop_ff, pop_in;
   logic [1:0]       status_ff, status_in;
   logic [deq_pkg::OCC_WIDTH-1:0] occ_ff, occ_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [63:0]           push_ext;
   logic signed [63:0]    rd_ext;
   logic [IDX_W-1:0]      front_prev, front_next, back_prev, back_next;
   deq_pkg::req_kind_type req_kind;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] p);
      return (p == '0) ? IDX_W'(DEPTH - 1) : p - 1'b1;
   endfunction

   assign req_tready = !pend_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign req_kind   = deq_pkg::req_kind_type'(req_tuser);

   assign front_prev = prev_idx(front_ff);
   assign front_next = next_idx(front_ff);
   assign back_prev  = prev_idx(back_ff);
   assign back_next  = next_idx(back_ff);

   // keep the low DATA_WIDTH bits of the 32-bit word, zero above it
   assign push_ext = {32'd0, req_tdata};
   assign wr_data  = push_ext[DATA_WIDTH-1:0];
   // stored word sign-extended, then cut to 32 bits
   assign rd_ext   = 64'(signed'(rd_data));

   always_comb begin
      front_in     = front_ff;
      back_in      = back_ff;
      count_in     = count_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop_in       = pop_ff;
      status_in    = status_ff;
      occ_in       = occ_ff;
      wr_en        = 1'b0;
      wr_addr      = back_ff;
      rd_en        = 1'b0;
      rd_addr      = front_ff;

      if (pend_ff) begin
         // ram read of the popped word has returned
         rsp_valid_in = 1'b1;
         pop_in       = rd_ext[31:0];
      end

      if (accept) begin
         pop_in    = '0;
         status_in = deq_pkg::ST_OK;
         occ_in    = OCC_W'(count_ff);
         case (req_kind)
            deq_pkg::REQ_PUSH_BACK, deq_pkg::REQ_PUSH_FRONT: begin
               rsp_valid_in = 1'b1;
               if (full) begin
                  status_in = deq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (req_kind == deq_pkg::REQ_PUSH_BACK) begin
                     wr_addr = back_ff;
                     back_in = back_next;
                  end else begin
                     wr_addr  = front_prev;
                     front_in = front_prev;
                  end
               end
            end
            deq_pkg::REQ_POP_BACK, deq_pkg::REQ_POP_FRONT: begin
               if (empty) begin
                  rsp_valid_in = 1'b1;
                  status_in    = deq_pkg::ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  pend_in  = 1'b1;
                  count_in = count_ff - 1'b1;
                  if (req_kind == deq_pkg::REQ_POP_BACK) begin
                     rd_addr = back_prev;
                     back_in = back_prev;
                  end else begin
                     rd_addr  = front_ff;
                     front_in = front_next;
                  end
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
         occ_in = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pop_ff    <= pop_in;
      status_ff <= status_in;
      occ_ff    <= occ_in;
   end

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, occ_ff, pop_ff};
   assign rsp_tuser  = status_ff;

endmodule

>>> hw/rtl/deq_ram.sv
// generic single-write, single-read synchronous ram with a registered read port
// no dependencies
module deq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
